>>> rtl/core/wav_header_checker_macros.svh
// Assertion macros for the WAV header checker.
// Used by wavh_parse and wav_header_checker; no other dependencies.
`ifndef WAV_HEADER_CHECKER_MACROS_SVH
`define WAV_HEADER_CHECKER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define WAVH_ASSERT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wavh: assertion failed");
// next-cycle implication
`define WAVH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wavh: assertion failed");
`else
`define WAVH_ASSERT(label, clk, rst_n, ante, cons)
`define WAVH_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> rtl/core/wavh_pkg.sv
// Shared types, constants and header tables for the WAV header checker.
// No dependencies.
`timescale 1ns / 1ps

package wavh_pkg;

  localparam logic [5:0] HEADER_BYTES = 6'd44;
  localparam logic [5:0] LAST_OFF     = HEADER_BYTES - 6'd1;
  localparam int unsigned FIELD_WORDS = 9;

  localparam logic [31:0] FMT_SIZE_PCM  = 32'd16;
  localparam logic [15:0] FORMAT_PCM    = 16'd1;
  localparam logic [31:0] RIFF_SIZE_ADJ = 32'd8;

  // configuration reset values
  localparam logic [3:0]  RST_CHANNELS    = 4'd2;
  localparam logic [31:0] RST_SAMPLE_RATE = 32'd44100;
  localparam logic [31:0] RST_BYTE_RATE   = 32'd44100 * 32'd2 * 32'd2;
  localparam logic [15:0] RST_BLOCK_ALIGN = 16'd4;
  localparam logic [15:0] RST_BITS        = 16'd16;
  localparam logic [31:0] RST_MIN_DATA    = 32'd16384;

  typedef enum logic [2:0] {
    CFG_CHANNELS    = 3'd0,
    CFG_SAMPLE_RATE = 3'd1,
    CFG_BYTE_RATE   = 3'd2,
    CFG_BLOCK_ALIGN = 3'd3,
    CFG_BITS        = 3'd4,
    CFG_MIN_DATA    = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_RIFF_TAG    = 3'd1,
    ST_WAVE_TAG    = 3'd2,
    ST_DATA_TAG    = 3'd3,
    ST_FMT_SIZE    = 3'd4,
    ST_COMPRESSION = 3'd5,
    ST_CHANNELS    = 3'd6,
    ST_FORMAT      = 3'd7
  } status_e;

  typedef struct packed {
    logic [3:0]  channels;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] bits;
    logic [31:0] min_data;
  } cfg_t;

  // parser to checker
  typedef struct packed {
    logic       last;
    logic [2:0] tag_fail;   // bit 0 RIFF, bit 1 WAVEfmt, bit 2 data
  } parse_ctl_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] slot;
    logic [1:0] lane;
  } slot_t;

  typedef logic [FIELD_WORDS-1:0][31:0] words_t;

  // tag group per offset, 0 when the offset carries no tag byte
  function automatic logic [1:0] tag_group(input logic [5:0] off);
    logic [1:0] g;
    g = 2'd0;
    if (off <= 6'd3) g = 2'd1;
    else if (off >= 6'd8 && off <= 6'd15) g = 2'd2;
    else if (off >= 6'd36 && off <= 6'd39) g = 2'd3;
    return g;
  endfunction

  function automatic logic [7:0] tag_char(input logic [5:0] off);
    logic [7:0] c;
    unique case (off)
      6'd0:    c = 8'h52; // R
      6'd1:    c = 8'h49; // I
      6'd2:    c = 8'h46; // F
      6'd3:    c = 8'h46; // F
      6'd8:    c = 8'h57; // W
      6'd9:    c = 8'h41; // A
      6'd10:   c = 8'h56; // V
      6'd11:   c = 8'h45; // E
      6'd12:   c = 8'h66; // f
      6'd13:   c = 8'h6d; // m
      6'd14:   c = 8'h74; // t
      6'd15:   c = 8'h20; // space
      6'd36:   c = 8'h64; // d
      6'd37:   c = 8'h61; // a
      6'd38:   c = 8'h74; // t
      6'd39:   c = 8'h61; // a
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // field word and byte lane per offset
  function automatic slot_t slot_map(input logic [5:0] off);
    slot_t s;
    s = '{hit: 1'b0, slot: 4'd0, lane: 2'd0};
    unique case (off)
      6'd4, 6'd5, 6'd6, 6'd7:     s = '{hit: 1'b1, slot: 4'd0, lane: off[1:0]};
      6'd16, 6'd17, 6'd18, 6'd19: s = '{hit: 1'b1, slot: 4'd1, lane: off[1:0]};
      6'd20, 6'd21:               s = '{hit: 1'b1, slot: 4'd2, lane: {1'b0, off[0]}};
      6'd22, 6'd23:               s = '{hit: 1'b1, slot: 4'd3, lane: {1'b0, off[0]}};
      6'd24, 6'd25, 6'd26, 6'd27: s = '{hit: 1'b1, slot: 4'd4, lane: off[1:0]};
      6'd28, 6'd29, 6'd30, 6'd31: s = '{hit: 1'b1, slot: 4'd5, lane: off[1:0]};
      6'd32, 6'd33:               s = '{hit: 1'b1, slot: 4'd6, lane: {1'b0, off[0]}};
      6'd34, 6'd35:               s = '{hit: 1'b1, slot: 4'd7, lane: {1'b0, off[0]}};
      6'd40, 6'd41, 6'd42, 6'd43: s = '{hit: 1'b1, slot: 4'd8, lane: off[1:0]};
      default:                    s = '{hit: 1'b0, slot: 4'd0, lane: 2'd0};
    endcase
    return s;
  endfunction

endpackage

>>> rtl/core/wavh_cfg_regs.sv
// Configuration register file for the WAV header checker.
// Depends on wavh_pkg.
`timescale 1ns / 1ps

module wavh_cfg_regs
  import wavh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.channels    <= RST_CHANNELS;
      cfg_q.sample_rate <= RST_SAMPLE_RATE;
      cfg_q.byte_rate   <= RST_BYTE_RATE;
      cfg_q.block_align <= RST_BLOCK_ALIGN;
      cfg_q.bits        <= RST_BITS;
      cfg_q.min_data    <= RST_MIN_DATA;
    end else if (cfg_valid_i && cfg_ready_o) begin
      // unknown indexes are dropped
      unique case (cfg_index_i)
        CFG_CHANNELS:    cfg_q.channels    <= cfg_data_i[3:0];
        CFG_SAMPLE_RATE: cfg_q.sample_rate <= cfg_data_i;
        CFG_BYTE_RATE:   cfg_q.byte_rate   <= cfg_data_i;
        CFG_BLOCK_ALIGN: cfg_q.block_align <= cfg_data_i[15:0];
        CFG_BITS:        cfg_q.bits        <= cfg_data_i[15:0];
        CFG_MIN_DATA:    cfg_q.min_data    <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/core/wavh_parse.sv
// Byte offset tracking, tag compare and little-endian field assembly.
// Depends on wavh_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "wav_header_checker_macros.svh"

module wavh_parse
  import wavh_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,     // held word is consumed this cycle
  input  logic [7:0] byte_i,
  input  logic       first_i,
  output parse_ctl_t ctl_o,
  output words_t     words_o     // field words including the current word
);

  logic [5:0] offset_q, offset_d;
  logic [2:0] flags_q, flags_d;
  words_t     words_q, words_d;

  logic [5:0] off_raw, off;
  logic [2:0] flags_base, fail_mask;
  logic [1:0] grp;
  slot_t      sm;

  always_comb begin
    off_raw = first_i ? 6'd0 : offset_q;
    off     = (off_raw >= HEADER_BYTES) ? 6'd0 : off_raw;

    flags_base = (off == 6'd0) ? 3'b000 : flags_q;
    grp        = tag_group(off);
    fail_mask  = 3'b000;
    if (byte_i != tag_char(off)) begin
      unique case (grp)
        2'd1:    fail_mask = 3'b001;
        2'd2:    fail_mask = 3'b010;
        2'd3:    fail_mask = 3'b100;
        default: fail_mask = 3'b000;
      endcase
    end
    flags_d = flags_base | fail_mask;

    sm      = slot_map(off);
    words_d = words_q;
    for (int s = 0; s < FIELD_WORDS; s++) begin
      if (sm.hit && sm.slot == 4'(s)) begin
        words_d[s][{sm.lane, 3'b000} +: 8] = byte_i;
      end
    end

    offset_d = (off == LAST_OFF) ? 6'd0 : off + 6'd1;
  end

  assign ctl_o.last     = (off == LAST_OFF);
  assign ctl_o.tag_fail = flags_d;
  assign words_o        = words_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= 6'd0;
      flags_q  <= 3'b000;
    end else if (step_i) begin
      offset_q <= offset_d;
      flags_q  <= flags_d;
    end
  end

  // field words are always written before they are read
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      words_q <= words_d;
    end
  end

  `WAVH_ASSERT(a_off_range, clk_i, rst_ni, 1'b1, offset_q < HEADER_BYTES)
  `WAVH_ASSERT_NXT(a_restart, clk_i, rst_ni, step_i && first_i, offset_q == 6'd1)

endmodule

>>> rtl/core/wavh_check.sv
// Status selection in check order and the result register.
// Depends on wavh_pkg.
`timescale 1ns / 1ps

module wavh_check
  import wavh_pkg::*;
(
  input  logic        clk_i,
  input  logic        load_i,
  input  parse_ctl_t  ctl_i,
  input  words_t      words_i,
  input  cfg_t        cfg_i,
  output logic [2:0]  status_o,
  output logic [31:0] file_size_o,
  output logic [31:0] fmt_size_o,
  output logic [15:0] format_tag_o,
  output logic [15:0] channel_count_o,
  output logic [31:0] sample_rate_o,
  output logic [31:0] byte_rate_o,
  output logic [15:0] block_align_o,
  output logic [15:0] bits_per_sample_o,
  output logic [31:0] data_size_o
);

  status_e     status_d, status_q;
  logic [31:0] riff, fmt, rate, brate, dsize;
  logic [15:0] fmtag, chans, balign, bits;
  logic [31:0] file_size_q, fmt_size_q, rate_q, brate_q, dsize_q;
  logic [15:0] fmtag_q, chans_q, balign_q, bits_q;

  assign riff   = words_i[0];
  assign fmt    = words_i[1];
  assign fmtag  = words_i[2][15:0];
  assign chans  = words_i[3][15:0];
  assign rate   = words_i[4];
  assign brate  = words_i[5];
  assign balign = words_i[6][15:0];
  assign bits   = words_i[7][15:0];
  assign dsize  = words_i[8];

  always_comb begin
    priority if (ctl_i.tag_fail[0]) status_d = ST_RIFF_TAG;
    else if (ctl_i.tag_fail[1])     status_d = ST_WAVE_TAG;
    else if (ctl_i.tag_fail[2])     status_d = ST_DATA_TAG;
    else if (fmt != FMT_SIZE_PCM)   status_d = ST_FMT_SIZE;
    else if (fmtag != FORMAT_PCM)   status_d = ST_COMPRESSION;
    else if (chans != {12'd0, cfg_i.channels}) status_d = ST_CHANNELS;
    else if (rate != cfg_i.sample_rate || balign != cfg_i.block_align ||
             bits != cfg_i.bits || brate != cfg_i.byte_rate ||
             dsize < cfg_i.min_data) status_d = ST_FORMAT;
    else status_d = ST_OK;
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      status_q    <= status_d;
      file_size_q <= riff + RIFF_SIZE_ADJ;
      fmt_size_q  <= fmt;
      fmtag_q     <= fmtag;
      chans_q     <= chans;
      rate_q      <= rate;
      brate_q     <= brate;
      balign_q    <= balign;
      bits_q      <= bits;
      dsize_q     <= dsize;
    end
  end

  assign status_o          = status_q;
  assign file_size_o       = file_size_q;
  assign fmt_size_o        = fmt_size_q;
  assign format_tag_o      = fmtag_q;
  assign channel_count_o   = chans_q;
  assign sample_rate_o     = rate_q;
  assign byte_rate_o       = brate_q;
  assign block_align_o     = balign_q;
  assign bits_per_sample_o = bits_q;
  assign data_size_o       = dsize_q;

endmodule

>>> rtl/core/wav_header_checker.sv
// WAV header checker: takes a canonical 44-byte RIFF/WAVE PCM header one byte
// per word on the input channel (first_byte_i restarts the parse at offset 0;
// after offset 43 the next byte starts a new header) and, on the byte at
// offset 43, delivers one result word holding the status of the first failing
// check and all decoded fields. One byte is taken every cycle unless the input
// stalls: a byte sits in the input register while the parser and status compare
// work on it, and a header's result enters the output register as its last byte
// leaves the input register. The input stalls only when a header ends while the
// previous result is still held by a stalled output. Configuration is written
// through the cfg port, which is always ready, and must only change while idle.
// Depends on wavh_pkg, wavh_cfg_regs, wavh_parse, wavh_check and the macros.
`timescale 1ns / 1ps
`include "wav_header_checker_macros.svh"

module wav_header_checker
  import wavh_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // header bytes
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  header_byte_i,
  input  logic        first_byte_i,
  // results
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [31:0] file_size_o,
  output logic [31:0] fmt_size_o,
  output logic [15:0] format_tag_o,
  output logic [15:0] channel_count_o,
  output logic [31:0] sample_rate_o,
  output logic [31:0] byte_rate_o,
  output logic [15:0] block_align_o,
  output logic [15:0] bits_per_sample_o,
  output logic [31:0] data_size_o,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic       in_vld_q, out_vld_q;
  logic [7:0] byte_q;
  logic       first_q;
  logic       advance, in_accept, out_load;
  parse_ctl_t ctl;
  words_t     words;
  cfg_t       cfg;

  wavh_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // held word moves on unless it closes a header and the result slot is busy
  assign advance    = in_vld_q && (!ctl.last || !out_vld_q || !out_stall_i);
  assign out_load   = advance && ctl.last;
  assign in_stall_o = in_vld_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_accept) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q  <= header_byte_i;
      first_q <= first_byte_i;
    end
  end

  wavh_parse u_parse (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .byte_i  (byte_q),
    .first_i (first_q),
    .ctl_o   (ctl),
    .words_o (words)
  );

  wavh_check u_check (
    .clk_i             (clk_i),
    .load_i            (out_load),
    .ctl_i             (ctl),
    .words_i           (words),
    .cfg_i             (cfg),
    .status_o          (status_o),
    .file_size_o       (file_size_o),
    .fmt_size_o        (fmt_size_o),
    .format_tag_o      (format_tag_o),
    .channel_count_o   (channel_count_o),
    .sample_rate_o     (sample_rate_o),
    .byte_rate_o       (byte_rate_o),
    .block_align_o     (block_align_o),
    .bits_per_sample_o (bits_per_sample_o),
    .data_size_o       (data_size_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  assign out_valid_o = out_vld_q;

  `WAVH_ASSERT(a_stall_cause, clk_i, rst_ni, in_stall_o, out_vld_q && out_stall_i && ctl.last)
  `WAVH_ASSERT(a_load_free, clk_i, rst_ni, out_load, !out_vld_q || !out_stall_i)
  `WAVH_ASSERT_NXT(a_load_shows, clk_i, rst_ni, out_load, out_vld_q)

endmodule

>>> test/wav_header_checker_tb.sv
// Self-checking testbench for wav_header_checker: streams 44-byte RIFF/WAVE headers,
// predicts each header report in a scoreboard class and compares every field.
// Depends on wavh_pkg and the wav_header_checker RTL only.
`timescale 1ns / 1ps

module wav_header_checker_tb;
  import wavh_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned SETTLE       = 8;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned RANDOM_BYTES = 1080;

  // register indexes that the block ignores
  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;

  localparam logic [31:0] RIFF_TAG = "RIFF";
  localparam logic [63:0] WAVE_TAG = "WAVEfmt ";
  localparam logic [31:0] DATA_TAG = "data";

  // ways a generated header can be spoilt, one bit each in a flaw mask
  typedef enum int {
    FL_RIFF, FL_WAVE, FL_DATA, FL_FMT_SIZE, FL_FORMAT, FL_CHANS,
    FL_RATE, FL_BRATE, FL_ALIGN, FL_BITS, FL_DSIZE, FL_NOISE, FL_COUNT
  } flaw_e;

  typedef struct {
    status_e     status;
    logic [31:0] file_size;
    logic [31:0] fmt_size;
    logic [15:0] format_tag;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [31:0] byte_rate;
    logic [15:0] block_align;
    logic [15:0] bits_per_sample;
    logic [31:0] data_size;
  } header_report_t;

  class header_report_board;
    cfg_t           cfg;
    logic [5:0]     offset;
    logic [2:0]     tag_bad;
    logic [31:0]    riff_size, fmt_size, sample_rate, byte_rate, data_size;
    logic [15:0]    format_tag, channel_count, block_align, bit_depth;
    header_report_t report_q[$];
    int             errors;

    function new();
      cfg = '{channels: RST_CHANNELS, sample_rate: RST_SAMPLE_RATE,
              byte_rate: RST_BYTE_RATE, block_align: RST_BLOCK_ALIGN,
              bits: RST_BITS, min_data: RST_MIN_DATA};
      offset = '0;
      tag_bad = '0;
      riff_size = '0; fmt_size = '0; sample_rate = '0; byte_rate = '0; data_size = '0;
      format_tag = '0; channel_count = '0; block_align = '0; bit_depth = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        CFG_CHANNELS:    cfg.channels    = d[3:0];
        CFG_SAMPLE_RATE: cfg.sample_rate = d;
        CFG_BYTE_RATE:   cfg.byte_rate   = d;
        CFG_BLOCK_ALIGN: cfg.block_align = d[15:0];
        CFG_BITS:        cfg.bits        = d[15:0];
        CFG_MIN_DATA:    cfg.min_data    = d;
        default: ;
      endcase
    endfunction

    function int pending();
      return report_q.size();
    endfunction

    // one accepted header byte; queues a report when offset 43 goes past
    function void take_byte(logic [7:0] b, logic first);
      logic [5:0]     off;
      header_report_t r;
      if (first) begin
        offset = '0;
        tag_bad = '0;
      end
      off = offset;
      if (off >= HEADER_BYTES) off = '0;
      if (off == 6'd0) tag_bad = '0;

      if (off <= 6'd3) begin
        if (b != RIFF_TAG[8*(3-off) +: 8]) tag_bad[0] = 1'b1;
      end else if (off >= 6'd8 && off <= 6'd15) begin
        if (b != WAVE_TAG[8*(15-off) +: 8]) tag_bad[1] = 1'b1;
      end else if (off >= 6'd36 && off <= 6'd39) begin
        if (b != DATA_TAG[8*(39-off) +: 8]) tag_bad[2] = 1'b1;
      end

      if (off >= 6'd4 && off <= 6'd7)        riff_size[8*(off-4) +: 8]     = b;
      else if (off >= 6'd16 && off <= 6'd19) fmt_size[8*(off-16) +: 8]     = b;
      else if (off >= 6'd20 && off <= 6'd21) format_tag[8*(off-20) +: 8]   = b;
      else if (off >= 6'd22 && off <= 6'd23) channel_count[8*(off-22) +: 8] = b;
      else if (off >= 6'd24 && off <= 6'd27) sample_rate[8*(off-24) +: 8]  = b;
      else if (off >= 6'd28 && off <= 6'd31) byte_rate[8*(off-28) +: 8]    = b;
      else if (off >= 6'd32 && off <= 6'd33) block_align[8*(off-32) +: 8]  = b;
      else if (off >= 6'd34 && off <= 6'd35) bit_depth[8*(off-34) +: 8]    = b;
      else if (off >= 6'd40 && off <= 6'd43) data_size[8*(off-40) +: 8]    = b;

      if (off != LAST_OFF) begin
        offset = off + 6'd1;
        return;
      end
      offset = '0;

      if (tag_bad[0])                              r.status = ST_RIFF_TAG;
      else if (tag_bad[1])                         r.status = ST_WAVE_TAG;
      else if (tag_bad[2])                         r.status = ST_DATA_TAG;
      else if (fmt_size != FMT_SIZE_PCM)           r.status = ST_FMT_SIZE;
      else if (format_tag != FORMAT_PCM)           r.status = ST_COMPRESSION;
      else if (channel_count != {12'd0, cfg.channels}) r.status = ST_CHANNELS;
      else if (sample_rate != cfg.sample_rate || block_align != cfg.block_align ||
               bit_depth != cfg.bits || byte_rate != cfg.byte_rate ||
               data_size < cfg.min_data)           r.status = ST_FORMAT;
      else                                         r.status = ST_OK;
      r.file_size       = riff_size + RIFF_SIZE_ADJ;
      r.fmt_size        = fmt_size;
      r.format_tag      = format_tag;
      r.channel_count   = channel_count;
      r.sample_rate     = sample_rate;
      r.byte_rate       = byte_rate;
      r.block_align     = block_align;
      r.bits_per_sample = bit_depth;
      r.data_size       = data_size;
      report_q.push_back(r);
    endfunction

    function void cmp(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      end
    endfunction

    function void check_report(header_report_t got);
      header_report_t want;
      if (report_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected report, expected none, actual status %0d file_size %h",
                 $time, got.status, got.file_size);
        return;
      end
      want = report_q.pop_front();
      cmp("status",          32'(want.status),          32'(got.status));
      cmp("file_size",       want.file_size,            got.file_size);
      cmp("fmt_size",        want.fmt_size,             got.fmt_size);
      cmp("format_tag",      32'(want.format_tag),      32'(got.format_tag));
      cmp("channel_count",   32'(want.channel_count),   32'(got.channel_count));
      cmp("sample_rate",     want.sample_rate,          got.sample_rate);
      cmp("byte_rate",       want.byte_rate,            got.byte_rate);
      cmp("block_align",     32'(want.block_align),     32'(got.block_align));
      cmp("bits_per_sample", 32'(want.bits_per_sample), 32'(got.bits_per_sample));
      cmp("data_size",       want.data_size,            got.data_size);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic [7:0]  header_byte;
  logic        first_byte;
  logic        out_stall;
  logic        cfg_valid;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  logic        in_stall_o;
  logic        out_valid_o;
  logic        cfg_ready_o;
  logic [2:0]  status_o;
  logic [31:0] file_size_o, fmt_size_o, sample_rate_o, byte_rate_o, data_size_o;
  logic [15:0] format_tag_o, channel_count_o, block_align_o, bits_per_sample_o;

  header_report_board sb;
  header_report_t     seen;
  cfg_t               cur_cfg;
  logic [7:0]         hdr_buf [0:43];
  int unsigned        bytes_sent;
  int unsigned        cycles;
  logic               hold_req;
  logic               in_quiet;

  wav_header_checker uut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall_o),
    .header_byte_i     (header_byte),
    .first_byte_i      (first_byte),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall),
    .status_o          (status_o),
    .file_size_o       (file_size_o),
    .fmt_size_o        (fmt_size_o),
    .format_tag_o      (format_tag_o),
    .channel_count_o   (channel_count_o),
    .sample_rate_o     (sample_rate_o),
    .byte_rate_o       (byte_rate_o),
    .block_align_o     (block_align_o),
    .bits_per_sample_o (bits_per_sample_o),
    .data_size_o       (data_size_o),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // monitor: every word that crosses a handshake goes to the scoreboard
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready_o) sb.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall_o) sb.take_byte(header_byte, first_byte);
      if (out_valid_o && !out_stall) begin
        seen.status          = status_e'(status_o);
        seen.file_size       = file_size_o;
        seen.fmt_size        = fmt_size_o;
        seen.format_tag      = format_tag_o;
        seen.channel_count   = channel_count_o;
        seen.sample_rate     = sample_rate_o;
        seen.byte_rate       = byte_rate_o;
        seen.block_align     = block_align_o;
        seen.bits_per_sample = bits_per_sample_o;
        seen.data_size       = data_size_o;
        sb.check_report(seen);
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    else if (r < 85) return $urandom_range(3, 1);
    else if (r < 97) return $urandom_range(12, 4);
    else return $urandom_range(60, 20);
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(5, 0))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'hFFFF_FFF8 + $urandom_range(7, 0);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] nz32();
    logic [31:0] m;
    m = $urandom;
    if (m == 32'd0) m = 32'd1;
    return m;
  endfunction

  function automatic int unsigned pick_flaws();
    int unsigned r;
    r = $urandom_range(9, 0);
    if (r < 4) return 0;
    else if (r < 8) return 1 << $urandom_range(int'(FL_DSIZE), 0);
    else if (r < 9) return $urandom & ((1 << FL_COUNT) - 1);
    else return 1 << FL_NOISE;
  endfunction

  function automatic cfg_t phase_config(int n);
    cfg_t c;
    if (n == 0) begin
      c = '{channels: 4'd1, sample_rate: 32'd0, byte_rate: 32'd0,
            block_align: 16'd0, bits: 16'd0, min_data: 32'd0};
    end else if (n == 1) begin
      c = '{channels: 4'd8, sample_rate: '1, byte_rate: '1,
            block_align: '1, bits: '1, min_data: '1};
    end else if ($urandom_range(3, 0) == 0) begin
      c = '{channels: RST_CHANNELS, sample_rate: RST_SAMPLE_RATE,
            byte_rate: RST_BYTE_RATE, block_align: RST_BLOCK_ALIGN,
            bits: RST_BITS, min_data: RST_MIN_DATA};
    end else begin
      c.channels    = ($urandom_range(4, 0) == 0) ? 4'($urandom) : 4'($urandom_range(8, 1));
      c.sample_rate = pick_word();
      c.byte_rate   = pick_word();
      c.block_align = 16'(pick_word());
      c.bits        = 16'(pick_word());
      c.min_data    = $urandom_range(1, 0) ? $urandom_range(65536, 0) : pick_word();
    end
    return c;
  endfunction

  task automatic put_le(input int off, input int n, input logic [31:0] v);
    for (int i = 0; i < n; i++) hdr_buf[off+i] = v[8*i +: 8];
  endtask

  task automatic fill_header(input logic [7:0] v);
    for (int i = 0; i < 44; i++) hdr_buf[i] = v;
  endtask

  // a header that matches the current settings, then spoilt as the mask says
  task automatic build_header(input int unsigned flaws);
    logic [31:0] riff_sz, fmt_sz, rate, brate, dsz;
    logic [15:0] ftag, chans, balign, depth;
    int          p;
    riff_sz = pick_word();
    fmt_sz  = FMT_SIZE_PCM;
    ftag    = FORMAT_PCM;
    chans   = 16'(cur_cfg.channels);
    rate    = cur_cfg.sample_rate;
    brate   = cur_cfg.byte_rate;
    balign  = cur_cfg.block_align;
    depth   = cur_cfg.bits;
    case ($urandom_range(2, 0))
      0: dsz = cur_cfg.min_data;
      1: dsz = 32'hFFFF_FFFF;
      default: dsz = $urandom_range(32'hFFFF_FFFF, cur_cfg.min_data);
    endcase
    if (flaws[FL_FMT_SIZE]) fmt_sz = fmt_sz ^ nz32();
    if (flaws[FL_FORMAT])   ftag   = ftag ^ 16'($urandom_range(65535, 1));
    if (flaws[FL_CHANS])    chans  = chans ^ 16'($urandom_range(65535, 1));
    if (flaws[FL_RATE])     rate   = rate ^ nz32();
    if (flaws[FL_BRATE])    brate  = brate ^ nz32();
    if (flaws[FL_ALIGN])    balign = balign ^ 16'($urandom_range(65535, 1));
    if (flaws[FL_BITS])     depth  = depth ^ 16'($urandom_range(65535, 1));
    if (flaws[FL_DSIZE] && cur_cfg.min_data != 32'd0)
      dsz = $urandom_range(cur_cfg.min_data - 32'd1, 0);

    for (int i = 0; i < 4; i++) hdr_buf[i]    = RIFF_TAG[8*(3-i) +: 8];
    for (int i = 0; i < 8; i++) hdr_buf[8+i]  = WAVE_TAG[8*(7-i) +: 8];
    for (int i = 0; i < 4; i++) hdr_buf[36+i] = DATA_TAG[8*(3-i) +: 8];
    put_le(4, 4, riff_sz);
    put_le(16, 4, fmt_sz);
    put_le(20, 2, 32'(ftag));
    put_le(22, 2, 32'(chans));
    put_le(24, 4, rate);
    put_le(28, 4, brate);
    put_le(32, 2, 32'(balign));
    put_le(34, 2, 32'(depth));
    put_le(40, 4, dsz);

    if (flaws[FL_RIFF]) begin
      p = $urandom_range(3, 0);
      hdr_buf[p] = hdr_buf[p] ^ (8'd1 << $urandom_range(7, 0));
    end
    if (flaws[FL_WAVE]) begin
      p = $urandom_range(15, 8);
      hdr_buf[p] = hdr_buf[p] ^ (8'd1 << $urandom_range(7, 0));
    end
    if (flaws[FL_DATA]) begin
      p = $urandom_range(39, 36);
      hdr_buf[p] = hdr_buf[p] ^ (8'd1 << $urandom_range(7, 0));
    end
    if (flaws[FL_NOISE])
      for (int i = 0; i < 44; i++) hdr_buf[i] = 8'($urandom);
  endtask

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_byte(input logic [7:0] b, input logic f);
    int unsigned gap;
    gap = in_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    header_byte <= b;
    first_byte  <= f;
    do @(posedge clk); while (in_stall_o);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_header(input int n, input logic f);
    for (int i = 0; i < n; i++) send_byte(hdr_buf[i], (i == 0) ? f : 1'b0);
  endtask

  // leaves cfg_valid high so back-to-back writes need no toggle
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready_o);
    @(negedge clk);
  endtask

  task automatic set_config(input cfg_t c);
    cfg_write(CFG_CHANNELS,    ($urandom & 32'hFFFF_FFF0) | 32'(c.channels));
    cfg_write(CFG_SAMPLE_RATE, c.sample_rate);
    cfg_write(CFG_BYTE_RATE,   c.byte_rate);
    cfg_write(CFG_BLOCK_ALIGN, ($urandom & 32'hFFFF_0000) | 32'(c.block_align));
    cfg_write(CFG_BITS,        ($urandom & 32'hFFFF_0000) | 32'(c.bits));
    cfg_write(CFG_MIN_DATA,    c.min_data);
    if ($urandom_range(1, 0))
      cfg_write($urandom_range(1, 0) ? CFG_SPARE_HI : CFG_SPARE_LO, $urandom);
    cfg_valid <= 1'b0;
    cur_cfg = c;
  endtask

  // drop valid, let every pending report out, then let the pipe empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // output back-pressure: calm stretches, random stalls, one long hold-off
  initial begin
    int unsigned k;
    int unsigned calm_left;
    logic        calm;
    out_stall = 1'b0;
    calm_left = 0;
    calm = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        k = LONG_HOLD;
      end else begin
        if (calm_left == 0) begin
          calm = ($urandom_range(3, 0) == 0);
          calm_left = $urandom_range(300, 50);
        end
        out_stall <= calm ? 1'b0 : 1'($urandom_range(1, 0));
        k = pick_gap() + 1;
      end
      calm_left = (calm_left > k) ? calm_left - k : 0;
      repeat (k) @(negedge clk);
    end
  end

  initial begin
    int unsigned rand_from;
    int          phase_no;
    int          left;
    int unsigned pick;
    int unsigned n;
    logic        restart;
    sb = new();
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    header_byte = 8'h00;
    first_byte  = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = 3'd0;
    cfg_data    = 32'd0;
    hold_req    = 1'b0;
    in_quiet    = 1'b0;
    bytes_sent  = 0;
    cur_cfg = '{channels: RST_CHANNELS, sample_rate: RST_SAMPLE_RATE,
                byte_rate: RST_BYTE_RATE, block_align: RST_BLOCK_ALIGN,
                bits: RST_BITS, min_data: RST_MIN_DATA};
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset settings, no start flag, wrap-around, each flaw alone
    build_header(0);
    send_header(44, 1'b0);
    build_header(0);
    put_le(4, 4, 32'hFFFF_FFFC);
    send_header(44, 1'b0);
    for (int f = 0; f < FL_NOISE; f++) begin
      build_header(1 << f);
      send_header(44, 1'b1);
    end
    build_header((1 << FL_NOISE) - 1);
    send_header(44, 1'b1);
    fill_header(8'h00);
    send_header(44, 1'b1);
    fill_header(8'hFF);
    send_header(44, 1'b1);
    // restart part way through: the partial header gives no report
    build_header(0);
    send_header(20, 1'b1);
    build_header(0);
    send_header(44, 1'b1);

    rand_from = bytes_sent;
    phase_no = 0;
    left = 0;
    restart = 1'b0;
    while ((bytes_sent - rand_from) < RANDOM_BYTES) begin
      if (left == 0) begin
        wait_idle();
        set_config(phase_config(phase_no));
        if (phase_no == 0) hold_req = 1'b1;
        phase_no++;
        // first phase runs long and gap-free so the long hold fills the block
        left = (phase_no == 1) ? 16 : $urandom_range(12, 4);
      end
      left--;
      in_quiet = (phase_no == 1) || ($urandom_range(3, 0) == 0);
      pick = $urandom_range(99, 0);
      if (pick < 78) begin
        build_header(pick_flaws());
        send_header(44, restart || ($urandom_range(7, 0) != 0));
        restart = 1'b0;
      end else if (pick < 90) begin
        build_header(pick_flaws());
        send_header($urandom_range(43, 1), restart || ($urandom_range(7, 0) != 0));
        restart = 1'b1;
      end else begin
        n = $urandom_range(10, 1);
        repeat (n) send_byte(8'($urandom), ($urandom_range(3, 0) == 0));
        restart = 1'b1;
      end
    end

    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
